// ----- hdl/udiv64_pkg.sv -----
// Shared types and constants for the 64-by-32 unsigned divider.
package udiv64_pkg;

    // Field widths.
    localparam int DVD_W = 64;
    localparam int DVS_W = 32;
    // The partial remainder needs one bit above the divisor.
    localparam int REM_W = DVS_W + 1;
    // Step counter width; it counts one step per dividend bit.
    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // Control that the sequencer broadcasts to every remainder cell.
    typedef struct packed {
        logic load;   // Clear the remainder bit and capture the divisor bit.
        logic step;   // Shift one place and keep the difference if it was taken.
        logic take;   // The trial subtraction did not borrow.
    } cell_ctrl_t;

endpackage

// ----- hdl/udiv64_cell.sv -----
// One bit slice of the partial remainder with its divisor bit and borrow stage.
module udiv64_cell (
    input  logic                   aclk,
    input  udiv64_pkg::cell_ctrl_t ctrl,
    input  logic                   dvs_bit,
    input  logic                   shift_in,
    input  logic                   borrow_in,
    output logic                   shift_out,
    output logic                   borrow_out
);

    logic r_reg;
    logic r_next;
    logic d_reg;
    logic diff;

    // Trial subtraction of the divisor bit from the shifted-in remainder bit.
    assign diff       = shift_in ^ d_reg ^ borrow_in;
    assign borrow_out = (~shift_in & d_reg) | (~(shift_in ^ d_reg) & borrow_in);
    assign shift_out  = r_reg;

    // Keep the difference when the whole row subtracted without a borrow.
    always_comb begin
        r_next = r_reg;
        if (ctrl.load) begin
            r_next = 1'b0;
        end else if (ctrl.step) begin
            r_next = ctrl.take ? diff : shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg <= r_next;
        if (ctrl.load) begin
            d_reg <= dvs_bit;
        end
    end

endmodule

// ----- hdl/udiv64_ctrl.sv -----
// Sequencer, dividend/quotient shift register and output register of the divider.
module udiv64_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [udiv64_pkg::DVD_W-1:0]        s_dividend,
    input  logic [udiv64_pkg::DVS_W-1:0]        s_divisor,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [udiv64_pkg::DVD_W-1:0]        m_quotient,
    output logic [udiv64_pkg::DVS_W-1:0]        m_remainder,
    output logic                                m_divide_error,
    input  logic                                no_borrow,
    input  logic [udiv64_pkg::DVS_W-1:0]        rem_bits,
    output logic                                dvd_msb,
    output udiv64_pkg::cell_ctrl_t              ctrl
);

    udiv64_pkg::state_t              state_reg, state_next;
    logic [udiv64_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [udiv64_pkg::DVD_W-1:0]    q_reg, q_next;
    logic                            err_reg, err_next;
    logic                            m_valid_reg, m_valid_next;
    logic [udiv64_pkg::DVD_W-1:0]    m_quo_reg;
    logic [udiv64_pkg::DVS_W-1:0]    m_rem_reg;
    logic                            m_err_reg;
    logic                            accept;
    logic                            out_load;

    assign s_ready  = (state_reg == udiv64_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == udiv64_pkg::ST_DONE) && (!m_valid_reg || m_ready);
    assign dvd_msb  = q_reg[udiv64_pkg::DVD_W-1];

    // Broadcast control for the cell row.
    assign ctrl.load = accept;
    assign ctrl.step = (state_reg == udiv64_pkg::ST_RUN);
    assign ctrl.take = no_borrow;

    // Sequencer: one quotient bit per cycle, then wait for the output register.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        err_next   = err_reg;
        case (state_reg)
            udiv64_pkg::ST_IDLE: begin
                if (accept) begin
                    q_next   = s_dividend;
                    cnt_next = '0;
                    err_next = (s_divisor == '0);
                    state_next = (s_divisor == '0) ? udiv64_pkg::ST_DONE
                                                   : udiv64_pkg::ST_RUN;
                end
            end
            udiv64_pkg::ST_RUN: begin
                // Dividend bits leave at the top while quotient bits enter below.
                q_next   = {q_reg[udiv64_pkg::DVD_W-2:0], no_borrow};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == udiv64_pkg::LAST_STEP) begin
                    state_next = udiv64_pkg::ST_DONE;
                end
            end
            udiv64_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = udiv64_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = udiv64_pkg::ST_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= udiv64_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        err_reg <= err_next;
        if (out_load) begin
            m_quo_reg <= err_reg ? '0 : q_reg;
            m_rem_reg <= err_reg ? '0 : rem_bits;
            m_err_reg <= err_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_quotient     = m_quo_reg;
    assign m_remainder    = m_rem_reg;
    assign m_divide_error = m_err_reg;

endmodule

// ----- hdl/unsigned_divider_64_by_32_core.sv -----
// Top level of the 64-by-32 unsigned restoring divider.
//
// Usage: present a word on the s_ channel (s_dividend, s_divisor) with s_valid;
// it is taken when s_valid and s_ready are both high. The result word appears on
// the m_ channel (m_quotient, m_remainder, m_divide_error) with m_valid and is
// taken when m_ready is high.
// The division runs through a row of 33 remainder bit cells, one quotient bit per
// clock, most significant first; the finished word then moves into the output
// register and m_valid rises. A zero divisor skips the row and gives quotient 0,
// remainder 0 and m_divide_error high.
// One word is in the cell row at a time; s_ready is high only while the row is
// free, so a new word is taken only after the last one has left the row.
// A finished word waits in the output register while m_ready is low, and the next
// word can be accepted meanwhile; that word then holds at the end of the row until
// the output register frees.
// Reset (aresetn low at a clock edge) empties the block: s_ready goes high and
// m_valid low.
module unsigned_divider_64_by_32_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [udiv64_pkg::DVD_W-1:0] s_dividend,
    input  logic [udiv64_pkg::DVS_W-1:0] s_divisor,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [udiv64_pkg::DVD_W-1:0] m_quotient,
    output logic [udiv64_pkg::DVS_W-1:0] m_remainder,
    output logic                         m_divide_error
);

    udiv64_pkg::cell_ctrl_t        ctrl;
    logic                          dvd_msb;
    logic [udiv64_pkg::REM_W:0]    shift_chain;
    logic [udiv64_pkg::REM_W:0]    borrow_chain;
    logic [udiv64_pkg::REM_W-1:0]  dvs_ext;

    // The top cell holds the extra remainder bit; its divisor bit is zero.
    assign dvs_ext         = {1'b0, s_divisor};
    assign shift_chain[0]  = dvd_msb;
    assign borrow_chain[0] = 1'b0;

    udiv64_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_dividend     (s_dividend),
        .s_divisor      (s_divisor),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_quotient     (m_quotient),
        .m_remainder    (m_remainder),
        .m_divide_error (m_divide_error),
        .no_borrow      (~borrow_chain[udiv64_pkg::REM_W]),
        .rem_bits       (shift_chain[udiv64_pkg::DVS_W:1]),
        .dvd_msb        (dvd_msb),
        .ctrl           (ctrl)
    );

    // Row of remainder cells; shift and borrow both run from low to high.
    for (genvar i = 0; i < udiv64_pkg::REM_W; i++) begin : g_cell
        udiv64_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .dvs_bit    (dvs_ext[i]),
            .shift_in   (shift_chain[i]),
            .borrow_in  (borrow_chain[i]),
            .shift_out  (shift_chain[i+1]),
            .borrow_out (borrow_chain[i+1])
        );
    end

endmodule

// ----- hdl/udiv64_checker.sv -----
// Port-level checks for the divider, bound to its top level.
module udiv64_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [udiv64_pkg::DVD_W-1:0] s_dividend,
    input logic [udiv64_pkg::DVS_W-1:0] s_divisor,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [udiv64_pkg::DVD_W-1:0] m_quotient,
    input logic [udiv64_pkg::DVS_W-1:0] m_remainder,
    input logic                         m_divide_error
);

    // A waiting input word holds until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_dividend) && $stable(s_divisor))
        else $error("input word changed while waiting");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quotient)
            && $stable(m_remainder) && $stable(m_divide_error))
        else $error("result word changed while stalled");

    // A divide error reports zero quotient and remainder.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_error |-> m_quotient == '0 && m_remainder == '0)
        else $error("divide error with nonzero result");

    // Only one word is in the row, so the input closes after acceptance.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // No result can appear in the cycle right after acceptance.
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

endmodule

bind unsigned_divider_64_by_32_core udiv64_checker u_udiv64_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_dividend     (s_dividend),
    .s_divisor      (s_divisor),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_quotient     (m_quotient),
    .m_remainder    (m_remainder),
    .m_divide_error (m_divide_error)
);
